// ===== src/mftd_pkg.sv =====
// Shared types, widths and reset constants for the median fire temperature detector.
// No dependencies; imported by the median selector and the top level.
package mftd_pkg;

  localparam int SAMPLE_W          = 16;
  localparam int NEEDED_W          = 5;
  localparam int CFG_IDX_W         = 2;
  localparam int DEF_MEDIAN_TAPS   = 5;
  localparam int DEF_HISTORY_DEPTH = 30;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [NEEDED_W-1:0]        needed_t;
  typedef logic [SAMPLE_W-1:0]        limit_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH_THRESHOLD    = 2'd0,
    REG_HIGH_COUNT_NEEDED = 2'd1,
    REG_RISE_LIMIT        = 2'd2
  } cfg_reg_t;

  localparam sample_t HIGH_THRESHOLD_RST    = 16'sd58;
  localparam needed_t HIGH_COUNT_NEEDED_RST = 5'd27;
  localparam limit_t  RISE_LIMIT_RST        = 16'd8;

endpackage

// ===== src/mftd_median.sv =====
// Combinational median selector over the raw sample taps (lower middle on even counts).
// Depends on mftd_pkg.
module mftd_median #(
  parameter int TAPS = mftd_pkg::DEF_MEDIAN_TAPS
) (
  input  mftd_pkg::sample_t taps_i [TAPS],
  output mftd_pkg::sample_t median_o
);
  import mftd_pkg::*;

  localparam int            RW  = $clog2(TAPS);
  localparam logic [RW-1:0] MID = RW'((TAPS - 1) / 2);

  logic [RW-1:0] rank [TAPS];

  // rank = position in stable ascending order; ties broken by tap index
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < TAPS; j++) begin
        if ((taps_i[j] < taps_i[i]) || ((taps_i[j] == taps_i[i]) && (j < i))) begin
          rank[i] = rank[i] + RW'(1);
        end
      end
    end
  end

  always_comb begin
    median_o = '0;
    for (int i = 0; i < TAPS; i++) begin
      if (rank[i] == MID) begin
        median_o = median_o | taps_i[i];
      end
    end
  end

endmodule

// ===== src/median_fire_temperature_detector_core.sv =====
// Items pass the input register, then the out_* registers; one item per cycle while in_stall stays low.
// The input register feeds median selection, window shift and alarm check on each step.
// Sync active-low reset clears fills, high count, flags and alarm; config regs take defaults.
// A high_threshold write starts a recount of the high-median count over HISTORY_DEPTH flags,
// during which in_stall is held high and cfg_ready is low.
module median_fire_temperature_detector_core #(
  parameter int MEDIAN_TAPS   = mftd_pkg::DEF_MEDIAN_TAPS,
  parameter int HISTORY_DEPTH = mftd_pkg::DEF_HISTORY_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mftd_pkg::sample_t              in_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mftd_pkg::sample_t              out_median_value,
  output logic                           out_median_valid,
  output logic                           out_alarm,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mftd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mftd_pkg::SAMPLE_W-1:0]  cfg_data
);
  import mftd_pkg::*;

  localparam int RFW    = $clog2(MEDIAN_TAPS + 1);
  localparam int MFW    = $clog2(HISTORY_DEPTH + 1);
  localparam int IDXW   = $clog2(HISTORY_DEPTH);
  localparam int CMPW   = (MFW > NEEDED_W) ? MFW : NEEDED_W;
  localparam int RISE_W = SAMPLE_W + 2;

  // control
  logic                     v0_r;
  logic                     out_v_r;
  logic [RFW-1:0]           raw_fill_r;
  logic [MFW-1:0]           med_fill_r;
  logic [MFW-1:0]           count_r;
  logic [HISTORY_DEPTH-1:0] flags_r;
  logic                     alarm_r;
  sample_t                  thr_r;
  needed_t                  needed_r;
  limit_t                   limit_r;
  logic                     rc_active_r;
  logic [IDXW-1:0]          rc_idx_r;

  // payload
  sample_t                  s_r;
  sample_t                  raw_r  [MEDIAN_TAPS-1];
  sample_t                  mwin_r [HISTORY_DEPTH];
  sample_t                  out_median_value_r;
  logic                     out_median_valid_r;
  logic                     out_alarm_r;

  logic                     advance;
  logic                     in_acc;
  logic                     step;
  logic                     cfg_acc;
  sample_t                  taps [MEDIAN_TAPS];
  sample_t                  med;
  logic                     raw_full;
  logic                     med_full;
  logic                     new_flag;
  logic [MFW-1:0]           cnt_new;
  logic signed [RISE_W-1:0] rise;
  logic                     cnt_hit;
  logic                     rise_hit;
  logic                     alarm_nxt;
  logic [HISTORY_DEPTH-1:0] flags_rc;

  assign advance   = !out_v_r || !out_stall;
  assign in_stall  = (v0_r && !advance) || cfg_valid || rc_active_r;
  assign in_acc    = in_valid && !in_stall;
  assign step      = v0_r && advance;
  assign cfg_ready = !v0_r && !rc_active_r;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_comb begin
    taps[0] = s_r;
    for (int i = 1; i < MEDIAN_TAPS; i++) begin
      taps[i] = raw_r[i-1];
    end
  end

  mftd_median #(
    .TAPS(MEDIAN_TAPS)
  ) u_median (
    .taps_i  (taps),
    .median_o(med)
  );

  always_comb begin
    raw_full  = raw_fill_r >= RFW'(MEDIAN_TAPS - 1);
    med_full  = med_fill_r >= MFW'(HISTORY_DEPTH - 1);
    new_flag  = med >= thr_r;
    cnt_new   = count_r + MFW'(new_flag) - MFW'(flags_r[HISTORY_DEPTH-1]);
    rise      = RISE_W'(s_r) - RISE_W'(mwin_r[HISTORY_DEPTH-2]);
    cnt_hit   = CMPW'(cnt_new) >= CMPW'(needed_r);
    rise_hit  = rise >= $signed({2'b00, limit_r});
    alarm_nxt = alarm_r || (raw_full && med_full && (cnt_hit || rise_hit));
  end

  // high flags re-evaluated against a newly written threshold
  always_comb begin
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      flags_rc[i] = (MFW'(i) < med_fill_r) && (mwin_r[i] >= $signed(cfg_data));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      out_v_r     <= 1'b0;
      raw_fill_r  <= '0;
      med_fill_r  <= '0;
      count_r     <= '0;
      flags_r     <= '0;
      alarm_r     <= 1'b0;
      thr_r       <= HIGH_THRESHOLD_RST;
      needed_r    <= HIGH_COUNT_NEEDED_RST;
      limit_r     <= RISE_LIMIT_RST;
      rc_active_r <= 1'b0;
      rc_idx_r    <= '0;
    end else begin
      if (in_acc) begin
        v0_r <= 1'b1;
      end else if (step) begin
        v0_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= v0_r;
      end
      if (step) begin
        if (raw_fill_r != RFW'(MEDIAN_TAPS)) begin
          raw_fill_r <= raw_fill_r + RFW'(1);
        end
        if (raw_full) begin
          if (med_fill_r != MFW'(HISTORY_DEPTH)) begin
            med_fill_r <= med_fill_r + MFW'(1);
          end
          flags_r <= {flags_r[HISTORY_DEPTH-2:0], new_flag};
          count_r <= cnt_new;
          alarm_r <= alarm_nxt;
        end
      end
      if (rc_active_r) begin
        count_r <= count_r + MFW'(flags_r[rc_idx_r]);
        if (rc_idx_r == IDXW'(HISTORY_DEPTH - 1)) begin
          rc_active_r <= 1'b0;
        end else begin
          rc_idx_r <= rc_idx_r + IDXW'(1);
        end
      end
      if (cfg_acc) begin
        unique case (cfg_index)
          REG_HIGH_THRESHOLD: begin
            thr_r       <= $signed(cfg_data);
            flags_r     <= flags_rc;
            count_r     <= '0;
            rc_active_r <= 1'b1;
            rc_idx_r    <= '0;
          end
          REG_HIGH_COUNT_NEEDED: needed_r <= cfg_data[NEEDED_W-1:0];
          REG_RISE_LIMIT:        limit_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_r <= in_sample;
    end
    if (step) begin
      raw_r[0] <= s_r;
      for (int i = 1; i < MEDIAN_TAPS - 1; i++) begin
        raw_r[i] <= raw_r[i-1];
      end
      if (raw_full) begin
        mwin_r[0] <= med;
        for (int i = 1; i < HISTORY_DEPTH; i++) begin
          mwin_r[i] <= mwin_r[i-1];
        end
      end
      out_median_value_r <= raw_full ? med : '0;
      out_median_valid_r <= raw_full;
      out_alarm_r        <= raw_full ? alarm_nxt : alarm_r;
    end
  end

  assign out_valid        = out_v_r;
  assign out_median_value = out_median_value_r;
  assign out_median_valid = out_median_valid_r;
  assign out_alarm        = out_alarm_r;

  a_alarm_sticky: assert property (@(posedge clk)
    rst_n && $past(rst_n) && $past(alarm_r) |-> alarm_r)
    else $error("alarm latch cleared without reset");

  a_count_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= med_fill_r)
    else $error("high count exceeds held medians");

  a_recount_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    rc_active_r |-> in_stall && !v0_r)
    else $error("item in flight during recount");

  a_median_valid_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_median_valid_r |-> raw_fill_r == RFW'(MEDIAN_TAPS))
    else $error("median reported before raw window full");

endmodule

// ===== bench/fire_detector_bench_pkg.sv =====
// Result predictor and scoreboard for the median fire temperature detector bench.
// Depends on mftd_pkg for the sample, count and limit types and the register indexes.
package fire_detector_bench_pkg;
  import mftd_pkg::*;

  localparam int TAPS  = DEF_MEDIAN_TAPS;
  localparam int DEPTH = DEF_HISTORY_DEPTH;

  // index past the last register; writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    sample_t median;
    logic    median_ok;
    logic    alarm;
  } reading_t;

  class fire_scoreboard;
    sample_t  raw_hist[TAPS];
    int       raw_count;
    sample_t  med_hist[DEPTH];
    int       med_count;
    bit       alarm_on;
    sample_t  threshold;
    needed_t  needed;
    limit_t   rise_lim;
    reading_t due[$];
    int       errors;
    int       checked;

    function new();
      threshold = HIGH_THRESHOLD_RST;
      needed    = HIGH_COUNT_NEEDED_RST;
      rise_lim  = RISE_LIMIT_RST;
      raw_count = 0;
      med_count = 0;
      alarm_on  = 1'b0;
      errors    = 0;
      checked   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
      case (idx)
        REG_HIGH_THRESHOLD:    threshold = data;
        REG_HIGH_COUNT_NEEDED: needed = data[NEEDED_W-1:0];
        REG_RISE_LIMIT:        rise_lim = data;
        default: ;
      endcase
    endfunction

    // lower middle of the sorted raw window
    function sample_t raw_median();
      sample_t sorted[TAPS];
      sample_t v;
      int      j;
      for (int i = 0; i < TAPS; i++) begin
        v = raw_hist[i];
        j = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      return sorted[(TAPS-1)/2];
    endfunction

    function void note_input(sample_t s);
      reading_t r;
      int       highs;
      int       rise;
      for (int i = TAPS-1; i > 0; i--) raw_hist[i] = raw_hist[i-1];
      raw_hist[0] = s;
      if (raw_count < TAPS) raw_count++;
      r.median    = '0;
      r.median_ok = 1'b0;
      if (raw_count == TAPS) begin
        r.median    = raw_median();
        r.median_ok = 1'b1;
        for (int i = DEPTH-1; i > 0; i--) med_hist[i] = med_hist[i-1];
        med_hist[0] = r.median;
        if (med_count < DEPTH) med_count++;
        if (med_count == DEPTH) begin
          highs = 0;
          foreach (med_hist[i]) if (med_hist[i] >= threshold) highs++;
          if (highs >= int'(needed)) alarm_on = 1'b1;
          rise = int'(s) - int'(med_hist[DEPTH-1]);
          if (rise >= int'(rise_lim)) alarm_on = 1'b1;
        end
      end
      r.alarm = alarm_on;
      due.push_back(r);
    endfunction

    function void check_result(sample_t median, logic median_ok, logic alarm);
      reading_t want;
      if (due.size() == 0) begin
        errors++;
        $error("result arrived with no item outstanding");
        return;
      end
      want = due.pop_front();
      checked++;
      if (median !== want.median) begin
        errors++;
        $error("median_value: expected %0d, actual %0d", want.median, median);
      end
      if (median_ok !== want.median_ok) begin
        errors++;
        $error("median_valid: expected %0b, actual %0b", want.median_ok, median_ok);
      end
      if (alarm !== want.alarm) begin
        errors++;
        $error("alarm: expected %0b, actual %0b", want.alarm, alarm);
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

endpackage

// ===== bench/tb.sv =====
// Top-level bench for median_fire_temperature_detector_core: drives samples and register
// writes with random gaps and stalls. Depends on mftd_pkg and fire_detector_bench_pkg.
module tb;
  import mftd_pkg::*;
  import fire_detector_bench_pkg::*;

  typedef enum int {
    END_COUNT, END_RISE, END_NEEDED_ZERO, END_RISE_ZERO, END_RISE_EXTREME
  } finale_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  sample_t              in_sample;
  logic                 out_valid;
  logic                 out_stall;
  sample_t              out_median_value;
  logic                 out_median_valid;
  logic                 out_alarm;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SAMPLE_W-1:0]  cfg_data;

  fire_scoreboard sb;
  bit             idling;
  int             results_seen;
  int             items_sent;
  int             cfg_writes;
  int             level;
  int             drift;
  sample_t        last_sample;

  median_fire_temperature_detector_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_median_value (out_median_value),
    .out_median_valid (out_median_valid),
    .out_alarm        (out_alarm),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_sample);
      if (out_valid && !out_stall) begin
        sb.check_result(out_median_value, out_median_valid, out_alarm);
        results_seen++;
      end
    end
  end

  // one long hold-off once traffic is flowing, otherwise random stall bursts while idling
  initial begin : result_sink
    int hold_left;
    bit long_hold_done;
    hold_left      = 0;
    long_hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!long_hold_done && results_seen >= 300) begin
        long_hold_done = 1'b1;
        hold_left      = 119;
        out_stall <= 1'b1;
      end else if (idling && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(0, 16);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic sample_t pick_sample(int walk_pct);
    int roll;
    int step;
    roll = $urandom_range(0, 99);
    if (roll < walk_pct) begin
      step  = $urandom_range(0, 20);
      level = level + step - 10 + drift;
      if (level > 32767) level = 32767;
      if (level < -32768) level = -32768;
      last_sample = sample_t'(level);
    end else if (roll < walk_pct + (100 - walk_pct) / 2) begin
      last_sample = sample_t'($urandom_range(0, 65535));
    end else if (roll < walk_pct + 3 * (100 - walk_pct) / 4) begin
      case ($urandom_range(0, 4))
        0: last_sample = 16'sh8000;
        1: last_sample = 16'sh7fff;
        2: last_sample = 16'sh0000;
        3: last_sample = 16'shffff;
        default: last_sample = 16'sh0001;
      endcase
    end
    // otherwise repeat the previous sample to create ties
    return last_sample;
  endfunction

  // call at a rising edge; returns at the edge where the item is taken
  task automatic send_sample(sample_t s);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, data);
    cfg_writes++;
  endtask

  task automatic apply_settings(sample_t th, needed_t nd, limit_t rl);
    logic [SAMPLE_W-1:0] nd_word;
    nd_word                = 16'($urandom);
    nd_word[NEEDED_W-1:0]  = nd;
    set_reg(REG_HIGH_THRESHOLD, th);
    set_reg(REG_HIGH_COUNT_NEEDED, nd_word);
    set_reg(REG_RISE_LIMIT, rl);
  endtask

  initial begin : stimulus
    int      directed_vals[$];
    int      t;
    int      n_final;
    sample_t th;
    needed_t nd;
    limit_t  rl;
    finale_t finale;

    sb           = new();
    idling       = 1'b1;
    results_seen = 0;
    items_sent   = 0;
    cfg_writes   = 0;
    level        = 0;
    drift        = 0;
    last_sample  = '0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_sample <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // most eager settings while the median window is still filling: alarm must stay low
    apply_settings(16'sh8000, '0, '0);
    directed_vals = '{-32768, 32767, -32768, 32767, 0, -1, 1, 58, 57, 59, 21845, -21846,
                      100, 100, 100, -5, 7, 7, -32768, -32768, 32767, 32767, 3, 2, 1};
    foreach (directed_vals[i]) send_sample(sample_t'(directed_vals[i]));
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin th = 16'sh8000; nd = 5'd31; rl = 16'hffff; end
        1: begin th = 16'sh7fff; nd = 5'd30; rl = 16'hffff; end
        2: begin
          th = sample_t'($urandom);
          nd = 5'd31;
          rl = limit_t'($urandom_range(65000, 65535));
        end
        3: begin th = 16'sh7fff; nd = needed_t'($urandom_range(3, 31)); rl = 16'hffff; end
        default: begin th = sample_t'($urandom); nd = 5'd31; rl = 16'hffff; end
      endcase
      apply_settings(th, nd, rl);
      if (p == 2) set_reg(REG_UNUSED, 16'($urandom));
      idling = (p != 1);
      t      = $urandom_range(0, 4000);
      level  = t - 2000;
      drift  = 0;
      repeat (250) send_sample(pick_sample(60));
      drain();
    end

    finale = finale_t'($urandom_range(0, 4));
    idling = 1'b1;
    drift  = 0;
    case (finale)
      END_COUNT: begin
        t     = $urandom_range(0, 2000);
        t     = t - 1000;
        level = t - 300;
        drift = 2;
        apply_settings(sample_t'(t), needed_t'($urandom_range(1, 30)), 16'hffff);
      end
      END_RISE: begin
        drift = 4;
        apply_settings(16'sh7fff, 5'd31, limit_t'($urandom_range(0, 300)));
      end
      END_NEEDED_ZERO: apply_settings(sample_t'($urandom), '0, 16'hffff);
      END_RISE_ZERO:   apply_settings(16'sh7fff, 5'd31, '0);
      default: begin
        // fill both windows with the coldest value, then the hottest raw sample
        apply_settings(16'sh7fff, 5'd31, 16'hffff);
        repeat (36) send_sample(16'sh8000);
        send_sample(16'sh7fff);
      end
    endcase
    n_final = (finale == END_COUNT || finale == END_RISE) ? 90 : 60;
    repeat (300) send_sample(pick_sample(n_final));
    idling = 1'b0;
    repeat (200) send_sample(pick_sample(n_final));
    drain();
    repeat (6) @(posedge clk);

    $display("Sent %0d samples under %0d register writes; %0d results checked.",
             items_sent, cfg_writes, sb.checked);
    $display("Closing case %s, alarm latched at end: %0b.", finale.name(), sb.alarm_on);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== median_fire_temperature_detector_core.f =====
src/mftd_pkg.sv
src/mftd_median.sv
src/median_fire_temperature_detector_core.sv
bench/fire_detector_bench_pkg.sv
bench/tb.sv
